FILE: hdl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants of the PWM duty capture block.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int TimeW     = 16;
  localparam int PeriodW   = 32;
  localparam int DutyW     = 15;
  localparam int DividendW = 31;

  localparam logic [DutyW-1:0]   DutyFull  = 15'd32767;
  localparam logic [TimeW:0]     WrapSpan  = 17'd65535;
  localparam logic [PeriodW-1:0] JumpLimit = 32'd20;
  localparam logic [2:0]         TickLimit = 3'd4;
  localparam logic [1:0]         BadLimit  = 2'd2;
  localparam logic [1:0]         BadMax    = 2'd3;
  localparam logic [1:0]         PhaseLast = 2'd2;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  localparam logic CFG_PERIOD_UPPER = 1'b0;
  localparam logic CFG_PERIOD_LOWER = 1'b1;

  typedef enum logic [1:0] {
    LV_NORMAL   = 2'd0,
    LV_HIGH     = 2'd1,
    LV_LOW      = 2'd2,
    LV_OVERFREQ = 2'd3
  } level_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [PeriodW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hdl/pdc_if.sv
// ----------------------------------------------------------------------------
// pdc_in_if / pdc_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface pdc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        pin_high;
  logic [15:0] start_time;
  logic [15:0] end_time;
  logic        wrap_pending;

  modport source (output valid, op, pin_high, start_time, end_time, wrap_pending,
                  input ready);
  modport sink (input valid, op, pin_high, start_time, end_time, wrap_pending,
                output ready);
endinterface

interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] duty;
  logic [1:0]  signal_state;
  logic        over_frequency;
  logic        duty_updated;

  modport source (output valid, duty, signal_state, over_frequency, duty_updated,
                  input ready);
  modport sink (input valid, duty, signal_state, over_frequency, duty_updated,
                output ready);
endinterface

FILE: hdl/pdc_div.sv
// ----------------------------------------------------------------------------
// pdc_div
// Restoring divider that produces one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module pdc_div (
  input  logic               clk,
  input  logic               rst,
  input  pdc_pkg::div_req_t  req,
  output pdc_pkg::div_rsp_t  rsp
);

  localparam int CntW = $clog2(pdc_pkg::DividendW + 1);

  logic [pdc_pkg::PeriodW-1:0]   rem;
  logic [pdc_pkg::DividendW-1:0] quo;
  logic [pdc_pkg::PeriodW-1:0]   divisor;
  logic [CntW-1:0]               cnt;
  logic                          done;
  logic [pdc_pkg::PeriodW:0]     trial;
  logic                          fits;

  assign trial = {rem, quo[pdc_pkg::DividendW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CntW'(pdc_pkg::DividendW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CntW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= pdc_pkg::PeriodW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[pdc_pkg::PeriodW-1:0];
      end
      quo <= {quo[pdc_pkg::DividendW-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: hdl/pwm_duty_capture.sv
// ----------------------------------------------------------------------------
// pwm_duty_capture
// Duty-cycle measurement of a PWM command input with stuck-pin detection.
// ----------------------------------------------------------------------------
// One word is taken at a time and each word returns one result word. A tick
// word passes through the tick and done states; a capture word passes through
// the capture states and the done state. Every third good capture recomputes
// the duty in the serial divider, which retires one quotient bit per cycle
// over a 31-bit dividend. When the averaged period is zero the divider is
// skipped. A stalled result word holds the block until it is taken. The
// input is ready again as soon as the result sits in the output register.
module pwm_duty_capture (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  pdc_in_if.sink       cap_in,
  pdc_out_if.source    res_out
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_TICK = 9'b000000010,
    S_CAP1 = 9'b000000100,
    S_CAP2 = 9'b000001000,
    S_CAP3 = 9'b000010000,
    S_CAP4 = 9'b000100000,
    S_CAP5 = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;

  logic [31:0] period_upper;
  logic [31:0] period_lower;

  logic        pin_r;
  logic        wrap_r;
  logic [15:0] start_r;
  logic [15:0] end_r;

  logic [15:0]      prev_end_time;
  logic [31:0]      prev_period;
  logic [15:0]      prev_pulse;
  logic [15:0]      overflow_ticks;
  logic [2:0]       high_ticks;
  logic [2:0]       low_ticks;
  logic             border_pending;
  logic [1:0]       capture_phase;
  logic [1:0]       bad_period_count;
  pdc_pkg::level_t  level_state;
  logic             over_freq_flag;
  logic [14:0]      duty_value;
  logic             updated;

  logic [31:0] period_r;
  logic [15:0] pulse_r;
  logic [15:0] ovf_r;

  logic                    out_valid;
  logic [14:0]             out_duty;
  logic [1:0]              out_state;
  logic                    out_of;
  logic                    out_upd;

  pdc_pkg::div_req_t div_req;
  pdc_pkg::div_rsp_t div_rsp;

  logic        clear;
  logic [15:0] ovf0;
  logic [15:0] ovf1;
  logic [15:0] ovf2;
  logic [15:0] pe;
  logic [16:0] pulse_wide;
  logic        bad;
  logic [1:0]  bad_next;
  logic [31:0] diff;
  logic [32:0] period_sum;
  logic [16:0] pulse_sum;
  logic        out_free;

  assign cap_in.ready = (state == S_IDLE) && !rst;
  assign out_free     = !out_valid || res_out.ready;

  always_comb begin
    clear = level_state inside {pdc_pkg::LV_HIGH, pdc_pkg::LV_LOW};
    ovf0  = clear ? 16'd0 : overflow_ticks;
    ovf1  = ovf0 + {15'd0, border_pending};
    ovf2  = (wrap_r && end_r[15]) ? ovf1 - 16'd1 : ovf1;
    pe    = clear ? 16'd0 : prev_end_time;
    if (end_r > start_r) begin
      pulse_wide = {1'b0, end_r} - {1'b0, start_r};
    end else begin
      pulse_wide = {1'b0, end_r} + pdc_pkg::WrapSpan - {1'b0, start_r};
    end
    bad      = (period_r > period_upper) || (period_r < period_lower);
    bad_next = (bad_period_count < pdc_pkg::BadMax) ? bad_period_count + 2'd1
                                                    : bad_period_count;
    diff = (period_r >= prev_period) ? period_r - prev_period : prev_period - period_r;
    period_sum = {1'b0, period_r} + {1'b0, prev_period};
    pulse_sum  = {1'b0, pulse_r} + {1'b0, prev_pulse};
  end

  always_comb begin
    div_req.start    = (state == S_CAP5) && (period_r != '0);
    div_req.dividend = {pulse_r, 15'd0} - {15'd0, pulse_r};
    div_req.divisor  = period_r;
  end

  pdc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period_upper <= 32'hFFFF_FFFF;
      period_lower <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pdc_pkg::CFG_PERIOD_UPPER: period_upper <= cfg_data;
        pdc_pkg::CFG_PERIOD_LOWER: period_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cap_in.valid && cap_in.ready) begin
      pin_r   <= cap_in.pin_high;
      wrap_r  <= cap_in.wrap_pending;
      start_r <= cap_in.start_time;
      end_r   <= cap_in.end_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      prev_end_time    <= '0;
      prev_period      <= '0;
      prev_pulse       <= '0;
      overflow_ticks   <= '0;
      high_ticks       <= '0;
      low_ticks        <= '0;
      border_pending   <= 1'b0;
      capture_phase    <= '0;
      bad_period_count <= '0;
      level_state      <= pdc_pkg::LV_NORMAL;
      over_freq_flag   <= 1'b0;
      duty_value       <= '0;
      updated          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && res_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          updated <= 1'b0;
          if (cap_in.valid) begin
            state <= (cap_in.op == pdc_pkg::OP_TICK) ? S_TICK : S_CAP1;
          end
        end
        S_TICK: begin
          overflow_ticks <= overflow_ticks + 16'd1;
          if (pin_r) begin
            low_ticks <= '0;
            if (high_ticks >= pdc_pkg::TickLimit) begin
              duty_value     <= pdc_pkg::DutyFull;
              over_freq_flag <= 1'b0;
              level_state    <= pdc_pkg::LV_HIGH;
              high_ticks     <= '0;
              overflow_ticks <= '0;
              updated        <= 1'b1;
            end else begin
              high_ticks <= high_ticks + 3'd1;
            end
          end else begin
            high_ticks <= '0;
            if (low_ticks >= pdc_pkg::TickLimit) begin
              duty_value     <= '0;
              over_freq_flag <= 1'b0;
              level_state    <= pdc_pkg::LV_LOW;
              low_ticks      <= '0;
              overflow_ticks <= '0;
              updated        <= 1'b1;
            end else begin
              low_ticks <= low_ticks + 3'd1;
            end
          end
          state <= S_DONE;
        end
        S_CAP1: begin
          if (clear) begin
            level_state <= pdc_pkg::LV_NORMAL;
            prev_period <= '0;
            prev_pulse  <= '0;
          end
          overflow_ticks <= '0;
          low_ticks      <= '0;
          high_ticks     <= '0;
          border_pending <= wrap_r && end_r[15];
          ovf_r          <= ovf2;
          pulse_r        <= pulse_wide[15:0];
          period_r       <= {16'd0, end_r} - {16'd0, pe};
          state          <= S_CAP2;
        end
        S_CAP2: begin
          period_r <= period_r + {ovf_r, 16'd0} - {16'd0, ovf_r};
          state    <= S_CAP3;
        end
        S_CAP3: begin
          prev_end_time <= end_r;
          state         <= S_DONE;
          if (bad) begin
            bad_period_count <= bad_next;
            if (bad_next >= pdc_pkg::BadLimit) begin
              over_freq_flag <= 1'b1;
              capture_phase  <= '0;
              level_state    <= pdc_pkg::LV_OVERFREQ;
            end
            prev_period <= period_r;
            prev_pulse  <= pulse_r;
          end else begin
            bad_period_count <= '0;
            level_state      <= pdc_pkg::LV_NORMAL;
            over_freq_flag   <= 1'b0;
            if (capture_phase < pdc_pkg::PhaseLast) begin
              capture_phase <= capture_phase + 2'd1;
              prev_period   <= period_r;
              prev_pulse    <= pulse_r;
            end else begin
              capture_phase <= '0;
              if (diff > pdc_pkg::JumpLimit) begin
                period_r <= prev_period;
              end
              state <= S_CAP4;
            end
          end
        end
        S_CAP4: begin
          period_r    <= period_sum[32:1];
          pulse_r     <= pulse_sum[16:1];
          prev_period <= period_sum[32:1];
          prev_pulse  <= pulse_sum[16:1];
          state       <= S_CAP5;
        end
        S_CAP5: begin
          updated <= 1'b1;
          if (period_r == '0) begin
            duty_value <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient > {16'd0, pdc_pkg::DutyFull}) begin
              duty_value <= pdc_pkg::DutyFull;
            end else begin
              duty_value <= div_rsp.quotient[14:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_duty  <= duty_value;
      out_state <= level_state;
      out_of    <= over_freq_flag;
      out_upd   <= updated;
    end
  end

  assign res_out.valid          = out_valid;
  assign res_out.duty           = out_duty;
  assign res_out.signal_state   = out_state;
  assign res_out.over_frequency = out_of;
  assign res_out.duty_updated   = out_upd;

endmodule

FILE: hdl/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks of the PWM duty capture block, bound to its top level.
// ----------------------------------------------------------------------------
module pdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] duty,
  input logic [1:0]  signal_state,
  input logic        over_frequency,
  input logic        duty_updated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  a_stuck_high_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_updated && signal_state == pdc_pkg::LV_HIGH |-> duty == pdc_pkg::DutyFull)
    else $error("stuck-high update without full duty");

  a_stuck_low_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_updated && signal_state == pdc_pkg::LV_LOW |-> duty == '0)
    else $error("stuck-low update without zero duty");

  a_overfreq_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> over_frequency == (signal_state == pdc_pkg::LV_OVERFREQ))
    else $error("over-frequency flag and state disagree");

endmodule

bind pwm_duty_capture pdc_checker u_pdc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (cap_in.valid),
  .in_ready       (cap_in.ready),
  .out_valid      (res_out.valid),
  .out_ready      (res_out.ready),
  .duty           (res_out.duty),
  .signal_state   (res_out.signal_state),
  .over_frequency (res_out.over_frequency),
  .duty_updated   (res_out.duty_updated)
);
